// File: rtl/pee_pkg.sv
// Shared types, character codes and controller/datapath link structs for the postfix evaluator.
package pee_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W              = 32;
   localparam int unsigned SYMBOL_W            = 8;
   localparam int unsigned STATUS_W            = 3;

   localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'd57;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [SYMBOL_W-1:0] CH_CLOSE = 8'h29;
   localparam logic [DATA_W-1:0]   RADIX    = 32'd10;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_RESULT  = 3'd1,
      ST_UNDER   = 3'd2,
      ST_OVER    = 3'd3,
      ST_DIVZERO = 3'd4,
      ST_DEPTH   = 3'd5
   } pee_status_type;

   typedef enum logic [1:0] {
      CLS_DIGIT = 2'd0,
      CLS_OPER  = 2'd1,
      CLS_END   = 2'd2,
      CLS_SEP   = 2'd3
   } pee_class_type;

   // Controller to datapath
   typedef struct packed {
      logic           load_symbol;
      logic           digit_step;
      logic           push;
      logic           drop_pending;
      logic           latch_error;
      logic           clear_all;
      logic           arith_capture;
      logic           div_start;
      logic           div_capture;
      logic           write_back;
      logic           out_load;
      pee_status_type out_status;
   } pee_cmd_type;

   // Datapath to controller
   typedef struct packed {
      pee_class_type sym_class;
      logic          is_div;
      logic          error_latched;
      logic          digit_seen;
      logic          stack_full;
      logic          under_two;
      logic          end_single;
      logic          tos_zero;
      logic          div_done;
   } pee_stat_type;

endpackage

// File: rtl/pee_if.sv
// Request and response channel interfaces for the postfix evaluator.
interface pee_req_if import pee_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface pee_rsp_if import pee_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

// File: rtl/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/pee_divider.sv
// Iterative restoring divider, one quotient bit per cycle, truncating signed result.
module pee_divider import pee_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] quotient,
   output logic              done
);

   localparam int unsigned CNT_W = $clog2(DATA_W);

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
      return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
   endfunction

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   diff;

   assign rem_shift = {rem_ff, quo_ff[DATA_W-1]};
   assign diff      = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = magnitude(dividend);
         rem_in  = '0;
         den_in  = magnitude(divisor);
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         // keep the difference when the shifted remainder covers the divisor
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;
   assign done     = done_ff;

endmodule

// File: rtl/pee_datapath.sv
// Datapath: symbol decode, pending number, operand stack, ALU, divider and response register.
module pee_datapath import pee_pkg::*; #(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SYMBOL_W-1:0]      req_symbol,
   input  pee_cmd_type              cmd,
   output pee_stat_type             stat,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_value
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   logic [SYMBOL_W-1:0] symbol_ff;
   logic [DATA_W-1:0]   pending_ff, pending_in;
   logic                digit_seen_ff, digit_seen_in;
   logic                error_ff, error_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [DATA_W-1:0]   tos_ff, tos_in;
   logic [DATA_W-1:0]   res_ff, res_in;
   pee_status_type      rsp_status_ff;
   logic [DATA_W-1:0]   rsp_value_ff;

   logic [CW-1:0]       left_idx;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [DATA_W-1:0]   ram_wdata;
   logic [DATA_W-1:0]   left_opnd;
   logic [DATA_W-1:0]   div_quot;
   logic                div_done;
   logic [DATA_W-1:0]   arith;
   logic [DATA_W-1:0]   end_value;
   pee_class_type       sym_class;

   // symbol decode
   always_comb begin
      unique case (symbol_ff) inside
         [CH_ZERO:CH_NINE]:                    sym_class = CLS_DIGIT;
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: sym_class = CLS_OPER;
         CH_CLOSE:                             sym_class = CLS_END;
         default:                              sym_class = CLS_SEP;
      endcase
   end

   assign left_idx = count_ff - CW'(2);

   always_comb begin
      case (symbol_ff)
         CH_PLUS:  arith = left_opnd + tos_ff;
         CH_MINUS: arith = left_opnd - tos_ff;
         default:  arith = left_opnd * tos_ff;
      endcase
   end

   assign end_value = digit_seen_ff ? pending_ff : tos_ff;

   assign ram_we    = cmd.push | cmd.write_back;
   assign ram_waddr = cmd.push ? count_ff[AW-1:0] : left_idx[AW-1:0];
   assign ram_wdata = cmd.push ? pending_ff : res_ff;

   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (left_idx[AW-1:0]),
      .rdata (left_opnd)
   );

   pee_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (left_opnd),
      .divisor  (tos_ff),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      pending_in    = pending_ff;
      digit_seen_in = digit_seen_ff;
      error_in      = error_ff;
      count_in      = count_ff;
      tos_in        = tos_ff;
      res_in        = res_ff;
      if (cmd.digit_step) begin
         pending_in    = pending_ff * RADIX + DATA_W'(symbol_ff - CH_ZERO);
         digit_seen_in = 1'b1;
      end
      if (cmd.push) begin
         tos_in        = pending_ff;
         count_in      = count_ff + CW'(1);
         pending_in    = '0;
         digit_seen_in = 1'b0;
      end
      if (cmd.drop_pending) begin
         pending_in    = '0;
         digit_seen_in = 1'b0;
         error_in      = 1'b1;
      end
      if (cmd.latch_error) begin
         error_in = 1'b1;
      end
      if (cmd.arith_capture) begin
         res_in = arith;
      end
      if (cmd.div_capture) begin
         res_in = div_quot;
      end
      if (cmd.write_back) begin
         tos_in   = res_ff;
         count_in = count_ff - CW'(1);
      end
      if (cmd.clear_all) begin
         pending_in    = '0;
         digit_seen_in = 1'b0;
         error_in      = 1'b0;
         count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         digit_seen_ff <= 1'b0;
         error_ff      <= 1'b0;
         count_ff      <= '0;
      end else begin
         pending_ff    <= pending_in;
         digit_seen_ff <= digit_seen_in;
         error_ff      <= error_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      res_ff <= res_in;
      if (cmd.load_symbol) begin
         symbol_ff <= req_symbol;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_value_ff  <= (cmd.out_status == ST_RESULT) ? end_value : '0;
      end
   end

   assign stat.sym_class     = sym_class;
   assign stat.is_div        = (symbol_ff == CH_SLASH);
   assign stat.error_latched = error_ff;
   assign stat.digit_seen    = digit_seen_ff;
   assign stat.stack_full    = (count_ff == CW'(STACK_DEPTH));
   assign stat.under_two     = (count_ff < CW'(2));
   assign stat.end_single    = digit_seen_ff ? (count_ff == '0) : (count_ff == CW'(1));
   assign stat.tos_zero      = (tos_ff == '0);
   assign stat.div_done      = div_done;

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = $signed(rsp_value_ff);

endmodule

// File: rtl/pee_controller.sv
// Controller state machine: sequences one request through decode, stack access and response.
module pee_controller import pee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  pee_stat_type stat,
   output pee_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_OPCHK = 7'b0000100,
      S_OPRD  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_DONE  = 7'b1000000
   } pee_state_type;

   pee_state_type  state_ff, state_in;
   pee_status_type status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.out_status = status_ff;
      state_in       = state_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_symbol = 1'b1;
               status_in       = ST_OK;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (stat.sym_class == CLS_END) begin
               if (stat.error_latched) begin
                  status_in = ST_OK;
               end else if (stat.digit_seen && stat.stack_full) begin
                  status_in = ST_OVER;
               end else if (stat.end_single) begin
                  status_in = ST_RESULT;
               end else begin
                  status_in = ST_DEPTH;
               end
            end else if (stat.error_latched) begin
               status_in = ST_OK;
            end else if (stat.sym_class == CLS_DIGIT) begin
               cmd.digit_step = 1'b1;
            end else begin
               // flush the pending number onto the stack, then operators go on to the operand check
               if (stat.digit_seen && stat.stack_full) begin
                  cmd.drop_pending = 1'b1;
                  status_in        = ST_OVER;
               end else begin
                  cmd.push = stat.digit_seen;
                  if (stat.sym_class == CLS_OPER) begin
                     state_in = S_OPCHK;
                  end
               end
            end
         end
         S_OPCHK: begin
            if (stat.under_two) begin
               cmd.latch_error = 1'b1;
               status_in       = ST_UNDER;
               state_in        = S_DONE;
            end else if (stat.is_div && stat.tos_zero) begin
               cmd.latch_error = 1'b1;
               status_in       = ST_DIVZERO;
               state_in        = S_DONE;
            end else begin
               // left operand is read from the stack memory this cycle
               state_in = S_OPRD;
            end
         end
         S_OPRD: begin
            if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.arith_capture = 1'b1;
               state_in          = S_WRITE;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load  = 1'b1;
               cmd.clear_all = (stat.sym_class == CLS_END);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator top level: one ASCII character per request, one response each.
// After acceptance, digits, separators and ')' pass through the execute and done states; + - *
// and / also pass the operand check and operand read, / waits in the divide state on the
// 32-step iterative divider, and a passed check ends in write-back. One request at a time: a
// response still waiting in the output register holds the next one back until it is taken.
// Synchronous active-high reset clears stack pointer, pending number, flags, FSM, response valid.
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pee_req_if.sink   req_ch,
   pee_rsp_if.source rsp_ch
);

   pee_cmd_type  cmd;
   pee_stat_type stat;

   // Controller: walks each request through decode and, for operators, operand read, ALU or
   // divider and write-back, then waits for a free output register before the next request.
   pee_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: holds the symbol, pending number and stack pointer; the top of stack lives in
   // a register so that only the left operand needs a memory read.
   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_ch.symbol),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_ch.status),
      .rsp_value  (rsp_ch.value)
   );

endmodule
